/* rtl/brf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_pkg - shared types and codes for the bisection root finder
// Result status codes, register indexes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package brf_pkg;

	// result status, carried on m_tuser
	typedef enum logic [1:0] {
		STATUS_CONVERGED = 2'd0,
		STATUS_INVALID   = 2'd1,
		STATUS_NO_CONV   = 2'd2
	} brf_status_t;

	// configuration register indexes
	localparam logic REG_TOLERANCE = 1'b0;
	localparam logic REG_MAX_ITER  = 1'b1;

	// sequencer states, one-hot
	typedef enum logic [6:0] {
		S_IDLE   = 7'b000_0001,
		S_EVAL_A = 7'b000_0010,
		S_EVAL_B = 7'b000_0100,
		S_MID    = 7'b000_1000,
		S_LOAD_M = 7'b001_0000,
		S_EVAL_M = 7'b010_0000,
		S_FINISH = 7'b100_0000
	} brf_state_t;

endpackage
`default_nettype wire

/* rtl/bisection_root_finder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bisection_root_finder - fixed-point bisection search for a root of
// f(x) = (x - 1) / (x + 1)
// Checks the end signs of the interval, then halves it until |f(m)| or the
// width falls under the tolerance, or the iteration limit is reached.
// ----------------------------------------------------------------------------
//
//  channel  direction  transfer            payload
//  s_*      in         s_tvalid & s_tready lower_bound, upper_bound
//  m_*      out        m_tvalid & m_tready status (tuser), root, iterations
//  cfg_*    in         cfg_we              tolerance, max_iterations
//
// One restoring divider forms every f value, one quotient bit per cycle,
// with a quotient of QW = 32 + FRAC_BITS bits (48 at Q16.16).
// The result becomes valid in the same cycle as s_tready returns high.
// s_tready is high only in idle; a stalled result waits in the output register.
// Reset clears the sequencer, the output valid and loads the register resets.

module bisection_root_finder #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [63:0] s_tdata,   // [31:0] lower_bound, [63:32] upper_bound
	// result stream
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [47:0] m_tdata,   // [31:0] root, [41:32] iterations, rest zero
	output      logic [1:0]  m_tuser,   // [1:0] status
	// configuration writes
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [30:0] cfg_data
);

	localparam int QW = 32 + FRAC_BITS;
	localparam int CW = $clog2(QW + 1);
	localparam logic [32:0] ONE33 = 33'(1) << FRAC_BITS;

	brf_pkg::brf_state_t  state_q;
	brf_pkg::brf_status_t res_status_q;

	logic [30:0] tol_q;
	logic [9:0]  max_iter_q;

	logic [31:0] a_q, b_q, m_q;
	logic [9:0]  iter_q;
	logic        width_ok_q;
	logic        sa_nz_q, sa_neg_q;

	// divider
	logic [QW-1:0] div_dvd_q;
	logic [31:0]   div_rem_q;
	logic [31:0]   den_mag_q;
	logic [CW-1:0] div_cnt_q;
	logic          div_neg_q;
	logic          div_load;
	logic [31:0]   div_x;
	logic [32:0]   div_num, div_den, num_mag, den_mag;
	logic [32:0]   div_trial, div_diff;
	logic          div_qbit;
	logic          q_nz, q_lt_tol;

	// output register
	logic                 out_valid_q;
	brf_pkg::brf_status_t out_status_q;
	logic [31:0]          out_root_q;
	logic [9:0]           out_iter_q;

	// midpoint and width
	logic [32:0] mid_sum, mid_diff, mid_absdiff;

	logic s_xfer, m_xfer, out_free;

	assign s_tready = (state_q == brf_pkg::S_IDLE);
	assign s_xfer   = s_tvalid & s_tready;
	assign m_xfer   = out_valid_q & m_tready;
	assign out_free = ~out_valid_q | m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_iter_q, out_root_q};
	assign m_tuser  = out_status_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q      <= 31'd66;
			max_iter_q <= 10'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				brf_pkg::REG_TOLERANCE: tol_q      <= cfg_data;
				brf_pkg::REG_MAX_ITER:  max_iter_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// operand selection for a new division
	always_comb begin
		div_load = 1'b0;
		div_x    = m_q;
		unique case (state_q)
			brf_pkg::S_IDLE: begin
				div_load = s_xfer;
				div_x    = s_tdata[31:0];
			end
			brf_pkg::S_EVAL_A: begin
				div_load = (div_cnt_q == '0);
				div_x    = b_q;
			end
			brf_pkg::S_LOAD_M: begin
				div_load = 1'b1;
				div_x    = m_q;
			end
			default: ;
		endcase
	end

	// numerator and denominator magnitudes of f(x)
	assign div_num = {div_x[31], div_x} - ONE33;
	assign div_den = {div_x[31], div_x} + ONE33;
	assign num_mag = div_num[32] ? (33'd0 - div_num) : div_num;
	assign den_mag = div_den[32] ? (33'd0 - div_den) : div_den;

	// one restoring step; a zero divisor yields an all-ones quotient
	assign div_trial = {div_rem_q, div_dvd_q[QW-1]};
	assign div_qbit  = (div_trial >= {1'b0, den_mag_q});
	assign div_diff  = div_trial - {1'b0, den_mag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (div_load) begin
			div_cnt_q <= CW'(QW);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			div_dvd_q <= {num_mag[31:0], {FRAC_BITS{1'b0}}};
			div_rem_q <= '0;
			den_mag_q <= den_mag[31:0];
			div_neg_q <= div_num[32] ^ div_den[32];
		end else if (div_cnt_q != '0) begin
			div_dvd_q <= {div_dvd_q[QW-2:0], div_qbit};
			div_rem_q <= div_qbit ? div_diff[31:0] : div_trial[31:0];
		end
	end

	// quotient magnitude tests; tolerance is below the saturation level
	assign q_nz     = |div_dvd_q;
	assign q_lt_tol = (div_dvd_q < {{(QW-31){1'b0}}, tol_q});

	// midpoint, rounding toward minus infinity, and interval width
	assign mid_sum     = {a_q[31], a_q} + {b_q[31], b_q};
	assign mid_diff    = {b_q[31], b_q} - {a_q[31], a_q};
	assign mid_absdiff = mid_diff[32] ? (33'd0 - mid_diff) : mid_diff;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brf_pkg::S_IDLE;
		end else begin
			unique case (state_q)
				brf_pkg::S_IDLE: begin
					if (s_xfer) state_q <= brf_pkg::S_EVAL_A;
				end
				brf_pkg::S_EVAL_A: begin
					if (div_cnt_q == '0) state_q <= brf_pkg::S_EVAL_B;
				end
				brf_pkg::S_EVAL_B: begin
					if (div_cnt_q == '0) begin
						if (!sa_nz_q || !q_nz || (sa_neg_q == div_neg_q))
							state_q <= brf_pkg::S_FINISH;
						else
							state_q <= brf_pkg::S_MID;
					end
				end
				brf_pkg::S_MID:    state_q <= brf_pkg::S_LOAD_M;
				brf_pkg::S_LOAD_M: state_q <= brf_pkg::S_EVAL_M;
				brf_pkg::S_EVAL_M: begin
					if (div_cnt_q == '0) begin
						if (q_lt_tol || width_ok_q || (iter_q >= max_iter_q))
							state_q <= brf_pkg::S_FINISH;
						else
							state_q <= brf_pkg::S_MID;
					end
				end
				brf_pkg::S_FINISH: begin
					if (out_free) state_q <= brf_pkg::S_IDLE;
				end
				default: state_q <= brf_pkg::S_IDLE;
			endcase
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			brf_pkg::S_IDLE: begin
				if (s_xfer) begin
					a_q    <= s_tdata[31:0];
					b_q    <= s_tdata[63:32];
					iter_q <= '0;
				end
			end
			brf_pkg::S_EVAL_A: begin
				if (div_cnt_q == '0) begin
					sa_nz_q  <= q_nz;
					sa_neg_q <= div_neg_q;
				end
			end
			brf_pkg::S_EVAL_B: begin
				if (div_cnt_q == '0) begin
					res_status_q <= brf_pkg::STATUS_INVALID;
					m_q          <= '0;
				end
			end
			brf_pkg::S_MID: begin
				m_q        <= mid_sum[32:1];
				iter_q     <= iter_q + 1'b1;
				width_ok_q <= (mid_absdiff < {2'b0, tol_q});
			end
			brf_pkg::S_EVAL_M: begin
				if (div_cnt_q == '0) begin
					if (q_lt_tol || width_ok_q) begin
						res_status_q <= brf_pkg::STATUS_CONVERGED;
					end else begin
						res_status_q <= brf_pkg::STATUS_NO_CONV;
						// keep the half whose end values differ in sign
						if (sa_nz_q && q_nz && (sa_neg_q != div_neg_q)) begin
							b_q <= m_q;
						end else begin
							a_q      <= m_q;
							sa_nz_q  <= q_nz;
							sa_neg_q <= div_neg_q;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == brf_pkg::S_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == brf_pkg::S_FINISH && out_free) begin
			out_status_q <= res_status_q;
			out_root_q   <= m_q;
			out_iter_q   <= iter_q;
		end
	end

	// checks
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> (state_q == brf_pkg::S_EVAL_A) && (div_cnt_q == CW'(QW)))
		else $error("divider not started on input transfer");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		(div_cnt_q != '0) |-> (state_q == brf_pkg::S_EVAL_A ||
			state_q == brf_pkg::S_EVAL_B || state_q == brf_pkg::S_EVAL_M))
		else $error("divider running outside an evaluation state");

	a_iter_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == brf_pkg::S_EVAL_M) |-> (iter_q != '0))
		else $error("midpoint evaluated without an iteration counted");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == brf_pkg::STATUS_INVALID) |->
			(out_root_q == '0 && out_iter_q == '0))
		else $error("invalid interval result carries root or count");

	a_conv_iter: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != brf_pkg::STATUS_INVALID) |-> (out_iter_q != '0))
		else $error("search result with zero iterations");

endmodule
`default_nettype wire
